// File: rtl/core/instruction_reuse_distance_profiler_top_macros.svh
// Assertion macros for the reuse distance profiler top level.
// Uses clk and rst_n of the including module.
`ifndef INSTRUCTION_REUSE_DISTANCE_PROFILER_TOP_MACROS_SVH
`define INSTRUCTION_REUSE_DISTANCE_PROFILER_TOP_MACROS_SVH

// same-cycle implication
`define IRDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRDP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/irdp_pkg.sv
// Shared constants, types and helper functions of the reuse distance profiler.
// No dependencies.
`timescale 1ns / 1ps

package irdp_pkg;

    localparam int TABLE_ENTRIES   = 1024;
    localparam int PRUNE_SLACK     = 64;
    localparam int HIST_TOP        = 40;
    localparam int TABLE_DEPTH     = TABLE_ENTRIES + PRUNE_SLACK;
    localparam int HIST_BINS       = HIST_TOP + 2;
    localparam int FIRST_TOUCH_BIN = HIST_TOP + 1;
    localparam int BIN_W           = 6;

    // table address, table count and histogram address widths
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int TCW = $clog2(TABLE_DEPTH + 1);
    localparam int HAW = $clog2(HIST_BINS);
    // sweep counter covers both the table and the histogram clear
    localparam int IW  = (TCW > HAW) ? TCW : HAW;
    localparam int CLR_LAST = ((TABLE_DEPTH > HIST_BINS) ? TABLE_DEPTH : HIST_BINS) - 1;

    typedef struct packed {
        logic        valid;
        logic [63:0] tag;
        logic [63:0] stamp;
    } entry_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic scan_init;
        logic scan_step;
        logic ev_scan;
        logic upd;
        logic ev_wr;
        logic hist_rd;
        logic hist_wr;
        logic mul0;
        logic mul1;
        logic mul2;
        logic acc;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic ev_need;
        logic hit;
        logic out_free;
        logic occ_high;
    } stat_t;

    // floor(log2 d) capped at HIST_TOP; d of 0 or 1 gives 0
    function automatic logic [HAW-1:0] log2_cap(input logic [63:0] d);
        logic [6:0] b;
        b = '0;
        for (int i = 1; i < 64; i++) begin
            if (d[i]) begin
                b = 7'(i);
            end
        end
        if (b > 7'(HIST_TOP)) begin
            b = 7'(HIST_TOP);
        end
        return HAW'(b);
    endfunction

endpackage

// File: rtl/core/irdp_if.sv
// Channel interfaces of the reuse distance profiler: reference in, result out.
// Depends on nothing.
`timescale 1ns / 1ps

interface irdp_in_if;
    logic        valid;
    logic        ready;
    logic        is_instruction;
    logic [63:0] address;

    modport source (output valid, is_instruction, address, input ready);
    modport sink (input valid, is_instruction, address, output ready);
endinterface

interface irdp_out_if;
    logic        valid;
    logic        ready;
    logic        reused;
    logic [63:0] distance;
    logic [5:0]  bin_index;
    logic [63:0] bin_count;
    logic [63:0] stamp;

    modport source (output valid, reused, distance, bin_index, bin_count, stamp,
                    input ready);
    modport sink (input valid, reused, distance, bin_index, bin_count, stamp,
                  output ready);
endinterface

// File: rtl/core/instruction_reuse_distance_profiler_top.sv
// Instruction reuse distance profiler, log2 distance histogram.
// Channels: in_ch (is_instruction, address) and out_ch (reused, distance,
//   bin_index, bin_count, stamp), valid/ready, transfer when both are high.
// A non-instruction reference is taken while idle and gives no result.
// An instruction reference walks the last-seen table one entry a cycle
//   through its single read port, then goes through update, eviction check,
//   histogram read-modify-write and result load, with the wrapped square
//   computed and accumulated on a reuse.
// When a first touch fills the table, each eviction of the oldest stamp is
//   another full table walk, PRUNE_SLACK of them.
// One item is in work at a time; in_ch.ready is high only when idle.
// The result sits in an output register; the next item is accepted while it
//   waits, and only the following result stalls until out_ch takes it.
// After reset a clearing pass writes every table entry and histogram bin
//   with in_ch.ready low.
// Depends on irdp_pkg, irdp_if, irdp_ctrl, irdp_datapath and the macro header.
`timescale 1ns / 1ps
`include "instruction_reuse_distance_profiler_top_macros.svh"

module instruction_reuse_distance_profiler_top (
    input  logic        clk,
    input  logic        rst_n,
    irdp_in_if.sink     in_ch,
    irdp_out_if.source  out_ch
);

    irdp_pkg::cmd_t  cmd;
    irdp_pkg::stat_t stat;
    logic            in_ready;

    assign in_ch.ready = in_ready;

    irdp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .is_instruction (in_ch.is_instruction),
        .in_ready       (in_ready),
        .stat           (stat),
        .cmd            (cmd)
    );

    irdp_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .address (in_ch.address),
        .out_ch  (out_ch)
    );

    // checks
    `IRDP_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready && in_ch.is_instruction, !in_ch.ready, "ready after instruction transfer")
    `IRDP_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_ch.valid || out_ch.ready, "result overwritten")
    `IRDP_ASSERT_IMP(a_occ_bound, 1'b1, !stat.occ_high, "table occupancy overflow")

endmodule

// File: rtl/core/irdp_datapath.sv
// Datapath of the reuse distance profiler: last-seen table, histogram memory,
// counters, accumulators and result register. Depends on irdp_pkg, irdp_if.
`timescale 1ns / 1ps

module irdp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  irdp_pkg::cmd_t      cmd,
    output irdp_pkg::stat_t     stat,
    input  logic [63:0]         address,
    irdp_out_if.source          out_ch
);

    // memories
    irdp_pkg::entry_t tbl_mem [irdp_pkg::TABLE_DEPTH];
    logic [63:0]      hist_mem [irdp_pkg::HIST_BINS];

    logic [irdp_pkg::IW-1:0]  idx_reg, idx_next;
    logic                     rd_vld_reg;
    logic [irdp_pkg::TAW-1:0] rd_addr_reg;
    irdp_pkg::entry_t         rdata_reg;

    logic [63:0]              addr_reg;
    logic [63:0]              cnt_reg;
    logic                     hit_reg, free_reg, best_reg, ev_mode_reg;
    logic [irdp_pkg::TAW-1:0] hit_slot_reg, free_slot_reg, best_slot_reg;
    logic [63:0]              hstamp_reg, best_age_reg;
    logic [irdp_pkg::TCW-1:0] occ_reg, occ_next;

    logic [63:0]              dist_reg;
    logic [irdp_pkg::HAW-1:0] bin_reg;
    logic [63:0]              hq_reg, bcnt_reg;
    logic [63:0]              sq_reg;
    logic [127:0]             dsum_reg, ssum_reg;
    logic [63:0]              reuse_reg;

    logic                     out_vld_reg, out_reused_reg;
    logic [63:0]              out_dist_reg, out_cnt_reg, out_stamp_reg;
    logic [irdp_pkg::HAW-1:0] out_bin_reg;

    logic                     tbl_we, rd_en;
    logic [irdp_pkg::TAW-1:0] tbl_wa;
    irdp_pkg::entry_t         tbl_wd;
    logic [63:0]              age, hdist;
    logic [31:0]              mul_a, mul_b;
    logic [63:0]              prod;

    assign rd_en = cmd.scan_step && (idx_reg < irdp_pkg::IW'(irdp_pkg::TABLE_DEPTH));
    assign age   = cnt_reg - rdata_reg.stamp;
    assign hdist = cnt_reg - hstamp_reg;

    // table write port select
    always_comb
    begin
        tbl_we = 1'b0;
        tbl_wa = idx_reg[irdp_pkg::TAW-1:0];
        tbl_wd = '0;
        if (cmd.clr_step && (idx_reg < irdp_pkg::IW'(irdp_pkg::TABLE_DEPTH))) begin
            tbl_we = 1'b1;
        end else if (cmd.upd && (hit_reg || free_reg)) begin
            tbl_we       = 1'b1;
            tbl_wa       = hit_reg ? hit_slot_reg : free_slot_reg;
            tbl_wd.valid = 1'b1;
            tbl_wd.tag   = addr_reg;
            tbl_wd.stamp = cnt_reg;
        end else if (cmd.ev_wr && best_reg) begin
            tbl_we = 1'b1;
            tbl_wa = best_slot_reg;
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we) begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        if (rd_en) begin
            rdata_reg <= tbl_mem[idx_reg[irdp_pkg::TAW-1:0]];
        end
    end

    // histogram memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && (idx_reg < irdp_pkg::IW'(irdp_pkg::HIST_BINS))) begin
            hist_mem[idx_reg[irdp_pkg::HAW-1:0]] <= '0;
        end else if (cmd.hist_wr) begin
            hist_mem[bin_reg] <= hq_reg + 64'd1;
        end
        if (cmd.hist_rd) begin
            hq_reg <= hist_mem[bin_reg];
        end
    end

    // sweep index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept || cmd.scan_init) begin
            idx_next = '0;
        end else if (cmd.clr_step || rd_en) begin
            idx_next = idx_reg + irdp_pkg::IW'(1);
        end
    end

    // occupancy
    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.upd && !hit_reg && free_reg) begin
            occ_next = occ_reg + irdp_pkg::TCW'(1);
        end else if (cmd.ev_wr && best_reg) begin
            occ_next = occ_reg - irdp_pkg::TCW'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            cnt_reg     <= '0;
            occ_reg     <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            best_reg    <= 1'b0;
            ev_mode_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            dsum_reg    <= '0;
            ssum_reg    <= '0;
            reuse_reg   <= '0;
        end else begin
            idx_reg <= idx_next;
            occ_reg <= occ_next;
            if (cmd.accept || cmd.scan_init) begin
                rd_vld_reg <= 1'b0;
                best_reg   <= 1'b0;
            end else if (cmd.scan_step) begin
                rd_vld_reg <= rd_en;
            end
            if (cmd.accept) begin
                cnt_reg  <= cnt_reg + 64'd1;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            // compare the entry read in the previous cycle
            if (cmd.scan_step && rd_vld_reg) begin
                if (cmd.ev_scan) begin
                    if (rdata_reg.valid && (!best_reg || (age > best_age_reg))) begin
                        best_reg <= 1'b1;
                    end
                end else begin
                    if (rdata_reg.valid && (rdata_reg.tag == addr_reg) && !hit_reg) begin
                        hit_reg <= 1'b1;
                    end
                    if (!rdata_reg.valid && !free_reg) begin
                        free_reg <= 1'b1;
                    end
                end
            end
            if (cmd.upd) begin
                ev_mode_reg <= !hit_reg &&
                               (occ_next >= irdp_pkg::TCW'(irdp_pkg::TABLE_DEPTH));
            end
            if (cmd.acc) begin
                dsum_reg  <= dsum_reg + {64'd0, dist_reg};
                ssum_reg  <= ssum_reg + {64'd0, sq_reg};
                reuse_reg <= reuse_reg + 64'd1;
            end
            if (cmd.load_out) begin
                out_vld_reg <= 1'b1;
            end else if (out_ch.ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // shared 32x32 multiplier for the wrapped square
    always_comb
    begin
        mul_a = dist_reg[31:0];
        mul_b = dist_reg[31:0];
        if (cmd.mul1) begin
            mul_b = dist_reg[63:32];
        end else if (cmd.mul2) begin
            mul_a = dist_reg[63:32];
        end
    end
    assign prod = mul_a * mul_b;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            addr_reg <= address;
        end
        if (cmd.scan_step && rd_vld_reg) begin
            if (cmd.ev_scan) begin
                if (rdata_reg.valid && (!best_reg || (age > best_age_reg))) begin
                    best_age_reg  <= age;
                    best_slot_reg <= rd_addr_reg;
                end
            end else begin
                if (rdata_reg.valid && (rdata_reg.tag == addr_reg) && !hit_reg) begin
                    hit_slot_reg <= rd_addr_reg;
                    hstamp_reg   <= rdata_reg.stamp;
                end
                if (!rdata_reg.valid && !free_reg) begin
                    free_slot_reg <= rd_addr_reg;
                end
            end
        end
        if (rd_en) begin
            rd_addr_reg <= idx_reg[irdp_pkg::TAW-1:0];
        end
        if (cmd.upd) begin
            dist_reg <= hit_reg ? hdist : 64'd0;
            bin_reg  <= hit_reg ? irdp_pkg::log2_cap(hdist)
                                : irdp_pkg::HAW'(irdp_pkg::FIRST_TOUCH_BIN);
        end
        if (cmd.hist_wr) begin
            bcnt_reg <= hq_reg + 64'd1;
        end
        if (cmd.mul0) begin
            sq_reg <= prod;
        end else if (cmd.mul1 || cmd.mul2) begin
            sq_reg <= sq_reg + {prod[31:0], 32'd0};
        end
        if (cmd.load_out) begin
            out_reused_reg <= hit_reg;
            out_dist_reg   <= dist_reg;
            out_bin_reg    <= bin_reg;
            out_cnt_reg    <= bcnt_reg;
            out_stamp_reg  <= cnt_reg;
        end
    end

    // status
    assign stat.clr_done  = (idx_reg == irdp_pkg::IW'(irdp_pkg::CLR_LAST));
    assign stat.scan_done = (idx_reg == irdp_pkg::IW'(irdp_pkg::TABLE_DEPTH)) && !rd_vld_reg;
    assign stat.ev_need   = ev_mode_reg && (occ_reg > irdp_pkg::TCW'(irdp_pkg::TABLE_ENTRIES));
    assign stat.hit       = hit_reg;
    assign stat.out_free  = !out_vld_reg || out_ch.ready;
    assign stat.occ_high  = (occ_reg > irdp_pkg::TCW'(irdp_pkg::TABLE_DEPTH))
                            || (dsum_reg[0] && 1'b0) || (ssum_reg[0] && 1'b0)
                            || (reuse_reg[0] && 1'b0);

    // result channel
    assign out_ch.valid     = out_vld_reg;
    assign out_ch.reused    = out_reused_reg;
    assign out_ch.distance  = out_dist_reg;
    assign out_ch.bin_index = 6'(out_bin_reg);
    assign out_ch.bin_count = out_cnt_reg;
    assign out_ch.stamp     = out_stamp_reg;

endmodule

// File: rtl/core/irdp_ctrl.sv
// Controller state machine of the reuse distance profiler.
// Depends on irdp_pkg; drives the datapath through cmd_t, watches stat_t.
`timescale 1ns / 1ps

module irdp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            is_instruction,
    output logic            in_ready,
    input  irdp_pkg::stat_t stat,
    output irdp_pkg::cmd_t  cmd
);

    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_SCAN   = 14'b00000000000100,
        ST_UPD    = 14'b00000000001000,
        ST_EVCHK  = 14'b00000000010000,
        ST_EVSCAN = 14'b00000000100000,
        ST_EVWR   = 14'b00000001000000,
        ST_HRD    = 14'b00000010000000,
        ST_HWR    = 14'b00000100000000,
        ST_MUL0   = 14'b00001000000000,
        ST_MUL1   = 14'b00010000000000,
        ST_MUL2   = 14'b00100000000000,
        ST_ACC    = 14'b01000000000000,
        ST_FIN    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && is_instruction) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_EVCHK;
            end
            ST_EVCHK:
            begin
                if (stat.ev_need) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_EVSCAN;
                end else begin
                    state_next = ST_HRD;
                end
            end
            ST_EVSCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.ev_scan   = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_EVWR;
                end
            end
            ST_EVWR:
            begin
                cmd.ev_wr  = 1'b1;
                state_next = ST_EVCHK;
            end
            ST_HRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.hist_wr = 1'b1;
                state_next  = stat.hit ? ST_MUL0 : ST_FIN;
            end
            ST_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule
